@@ hdl/ilir_pkg.sv @@
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list insert/remove unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = 7;   // position and count fields
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [1:0] CMD_GET    = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic  fire;   // a beat is accepted this cycle
        logic  ins;    // legal insert (append is an insert at the end)
        logic  rem;    // legal remove
        logic  rd;     // legal get or remove: tap the addressed cell
        cnt_t  pos;    // effective position
        cnt_t  count;  // fill count before the operation
        word_t word;   // word to store
    } bcast_t;

endpackage

`default_nettype wire

@@ hdl/ilir_cell.sv @@
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds, loads, or takes its neighbour's word; taps on read.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_cell (
    input  wire logic            aclk,
    input  wire ilir_pkg::cnt_t  idx,
    input  wire ilir_pkg::bcast_t bc,
    input  wire ilir_pkg::word_t prev_word,
    input  wire ilir_pkg::word_t next_word,
    output ilir_pkg::word_t      data,
    output ilir_pkg::word_t      tap
);

    ilir_pkg::word_t data_reg, data_next;
    ilir_pkg::word_t tap_reg, tap_next;
    logic [ilir_pkg::CNT_W:0] idx_plus;

    assign idx_plus = {1'b0, idx} + (ilir_pkg::CNT_W+1)'(1);

    always_comb begin
        data_next = data_reg;
        tap_next  = '0;
        if (bc.fire) begin
            if (bc.rd && (idx == bc.pos)) begin
                tap_next = data_reg;
            end
            if (bc.ins) begin
                if (idx == bc.pos) begin
                    data_next = bc.word;
                end else if ((idx > bc.pos) && (idx <= bc.count)) begin
                    data_next = prev_word;
                end
            end else if (bc.rem) begin
                if ((idx >= bc.pos) && (idx_plus < {1'b0, bc.count})) begin
                    data_next = next_word;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

`default_nettype wire

@@ hdl/ilir_or_tree.sv @@
// ----------------------------------------------------------------------------
// ilir_or_tree
// First level of the read-out tree: ORs cell taps in groups of eight.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_or_tree (
    input  wire logic            aclk,
    input  wire logic            load,
    input  wire ilir_pkg::word_t taps [ilir_pkg::CAPACITY],
    output ilir_pkg::word_t      groups [ilir_pkg::NUM_GROUPS]
);

    ilir_pkg::word_t grp_reg  [ilir_pkg::NUM_GROUPS];
    ilir_pkg::word_t grp_next [ilir_pkg::NUM_GROUPS];

    always_comb begin
        for (int g = 0; g < ilir_pkg::NUM_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < ilir_pkg::GROUP_SIZE; k++) begin
                if (g * ilir_pkg::GROUP_SIZE + k < ilir_pkg::CAPACITY) begin
                    grp_next[g] = grp_next[g] | taps[g * ilir_pkg::GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp_next;
        end
    end

    assign groups = grp_reg;

endmodule

`default_nettype wire

@@ hdl/indexed_list_insert_remove_unit.sv @@
// An accepted beat goes through the cell tap register, the OR-tree group register
//   and the output register before its result shows on m_*. The cell tap register
//   and the registered OR-tree stage must both empty before the next beat is taken.
// A stalled result may hold up the next beat while m_ready stays low.
// Reset (aresetn low, synchronous) empties the list and drops beats in
//   flight; the cell words are not cleared, only entries below count are read.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_unit
// Ordered list of signed words held in a chain of cells, with get, append,
// insert and remove at an index. Each cell shifts, loads or holds; the
// addressed word is read out through a registered OR tree.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_command,
    input  wire logic [6:0]          s_position,
    input  wire logic signed [31:0]  s_word_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic signed [31:0]       m_word_out,
    output logic [6:0]               m_count
);

    // ---- control state -----------------------------------------------------
    ilir_pkg::cnt_t count_reg, count_next;
    logic           v1_reg;      // taps are valid in the cells
    logic           v2_reg;      // group ORs are valid
    logic           m_valid_reg;

    // result side-band riding along with the word
    logic [1:0]     st1_reg, st2_reg, st_out_reg;
    ilir_pkg::cnt_t cnt1_reg, cnt2_reg, cnt_out_reg;
    ilir_pkg::word_t word_out_reg, word_or;

    logic           accept;
    logic           out_free;
    logic [1:0]     status_next;
    ilir_pkg::bcast_t bc;

    // Only one beat in flight; a finished result can wait in the output
    // register while the next beat goes through the cells.
    assign s_ready  = !v1_reg && !v2_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ---- command decode: status, new count, cell broadcast ---------------
    always_comb begin
        status_next = ilir_pkg::ST_OK;
        count_next  = count_reg;
        bc.fire     = accept;
        bc.ins      = 1'b0;
        bc.rem      = 1'b0;
        bc.rd       = 1'b0;
        bc.pos      = s_position;
        bc.count    = count_reg;
        bc.word     = s_word_in;
        case (s_command)
            ilir_pkg::CMD_GET: begin
                if (s_position >= count_reg) begin
                    status_next = ilir_pkg::ST_RANGE;
                end else begin
                    bc.rd = 1'b1;
                end
            end
            ilir_pkg::CMD_APPEND: begin
                bc.pos = count_reg;   // append is an insert at the end
                if (count_reg >= ilir_pkg::CNT_W'(ilir_pkg::CAPACITY)) begin
                    status_next = ilir_pkg::ST_FULL;
                end else begin
                    bc.ins     = 1'b1;
                    count_next = count_reg + ilir_pkg::CNT_W'(1);
                end
            end
            ilir_pkg::CMD_INSERT: begin
                // the position check goes before the full check
                if (s_position > count_reg) begin
                    status_next = ilir_pkg::ST_RANGE;
                end else if (count_reg >= ilir_pkg::CNT_W'(ilir_pkg::CAPACITY)) begin
                    status_next = ilir_pkg::ST_FULL;
                end else begin
                    bc.ins     = 1'b1;
                    count_next = count_reg + ilir_pkg::CNT_W'(1);
                end
            end
            ilir_pkg::CMD_REMOVE: begin
                if (s_position >= count_reg) begin
                    status_next = ilir_pkg::ST_RANGE;
                end else begin
                    bc.rem     = 1'b1;
                    bc.rd      = 1'b1;
                    count_next = count_reg - ilir_pkg::CNT_W'(1);
                end
            end
            default: begin
                status_next = ilir_pkg::ST_RANGE;
            end
        endcase
    end

    // ---- chain of cells ----------------------------------------------------
    ilir_pkg::word_t cell_data [ilir_pkg::CAPACITY];
    ilir_pkg::word_t cell_tap  [ilir_pkg::CAPACITY];
    ilir_pkg::word_t grp       [ilir_pkg::NUM_GROUPS];

    for (genvar i = 0; i < ilir_pkg::CAPACITY; i++) begin : g_cell
        ilir_pkg::word_t prev_w, next_w;
        if (i == 0) begin : g_head
            assign prev_w = '0;
        end else begin : g_mid_p
            assign prev_w = cell_data[i-1];
        end
        if (i == ilir_pkg::CAPACITY - 1) begin : g_tail
            assign next_w = '0;
        end else begin : g_mid_n
            assign next_w = cell_data[i+1];
        end
        ilir_cell u_cell (
            .aclk      (aclk),
            .idx       (ilir_pkg::CNT_W'(i)),
            .bc        (bc),
            .prev_word (prev_w),
            .next_word (next_w),
            .data      (cell_data[i]),
            .tap       (cell_tap[i])
        );
    end

    // ---- read-out tree -----------------------------------------------------
    ilir_or_tree u_tree (
        .aclk   (aclk),
        .load   (v1_reg),
        .taps   (cell_tap),
        .groups (grp)
    );

    always_comb begin
        word_or = '0;
        for (int g = 0; g < ilir_pkg::NUM_GROUPS; g++) begin
            word_or = word_or | grp[g];
        end
    end

    // ---- control registers -------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= accept ? count_next : count_reg;
            v1_reg    <= accept;
            if (v1_reg) begin
                v2_reg <= 1'b1;
            end else if (v2_reg && out_free) begin
                v2_reg <= 1'b0;
            end
            if (v2_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers -------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg  <= status_next;
            cnt1_reg <= count_next;
        end
        if (v1_reg) begin
            st2_reg  <= st1_reg;
            cnt2_reg <= cnt1_reg;
        end
        if (v2_reg && out_free) begin
            st_out_reg   <= st2_reg;
            cnt_out_reg  <= cnt2_reg;
            word_out_reg <= word_or;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = st_out_reg;
    assign m_word_out = word_out_reg;
    assign m_count    = cnt_out_reg;

    // ---- assertions --------------------------------------------------------
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ilir_pkg::CNT_W'(ilir_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v1_reg && v2_reg))
        else $error("two beats in flight");

    a_accept_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (v1_reg && !s_ready))
        else $error("accepted beat did not enter the cell stage");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ilir_pkg::ST_OK)) |-> (m_word_out == '0))
        else $error("failed command returned a word");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ilir_pkg::ST_FULL))
            |-> (m_count == ilir_pkg::CNT_W'(ilir_pkg::CAPACITY)))
        else $error("full status with list not full");

endmodule

`default_nettype wire
